// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_FULL   = 2'd2,
    STS_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_GET,
    S_INS_SOLO,
    S_INS_HEAD,
    S_INS_TAIL,
    S_WALK_START,
    S_WALK,
    S_LINK_RD,
    S_LINK_GET,
    S_INS_PREV,
    S_DEL_GET,
    S_DEL_HEAD,
    S_FREE,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

endpackage

// ===== rtl/ple_if.sv =====
`timescale 1ns / 1ps

interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::OPCODE_W-1:0]      opcode;
  logic signed [ple_pkg::VALUE_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::STATUS_W-1:0]      status;
  logic signed [ple_pkg::VALUE_W-1:0] element;
  logic [ple_pkg::COUNT_W-1:0]       count;
  logic                              last;

  modport source (output valid, status, element, count, last, input ready);
  modport sink   (input valid, status, element, count, last, output ready);
endinterface

// ===== rtl/ple_ram.sv =====
`timescale 1ns / 1ps

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload                              | Beat taken when
// req_i   | in  | opcode, value, position              | valid && ready
// rsp_o   | out | status, element, count, last         | valid && ready
//
// One request at a time; req_i.ready is high only while the sequencer idles.
// Positional requests walk the link RAM from the head, one read per cycle.
// Dump: the head entry is read first, then one beat per cycle while rsp_o.ready holds.
// Results sit in an output register, so a new request is taken while one waits.
// Reset clears head, tail, count and the slot allocator; RAM contents are not cleared.

module positional_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_req_if.sink    req_i,
  ple_rsp_if.source  rsp_o
);

  import ple_pkg::*;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  state_e                     state_q, state_d;
  logic [OPCODE_W-1:0]        op_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [POS_W-1:0]           pos_q;
  logic [CNT_W-1:0]           steps_q, steps_d;
  logic [SLOT_W-1:0]          cur_q, cur_d;
  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic [SLOT_W-1:0]          head_q, head_d;
  logic [SLOT_W-1:0]          tail_q, tail_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           fresh_q, fresh_d;
  status_e                    status_q, status_d;
  logic                       del_q, del_d;
  logic                       first_q, first_d;

  // output register
  logic                       ov_q;
  status_e                    ost_q;
  logic signed [VALUE_W-1:0]  oel_q;
  logic [COUNT_W-1:0]         ocnt_q;
  logic                       olast_q;
  logic                       out_load;
  status_e                    out_st;
  logic signed [VALUE_W-1:0]  out_el;
  logic                       out_last;
  logic                       out_free;

  // memory ports
  logic                       lk_we, lk_re;
  logic [SLOT_W-1:0]          lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic                       el_we, el_re;
  logic [SLOT_W-1:0]          el_waddr, el_raddr;
  logic [VALUE_W-1:0]         el_rdata;
  logic                       fs_we, fs_re;
  logic [SLOT_W-1:0]          fs_waddr, fs_wdata, fs_raddr, fs_rdata;

  // decode helpers
  logic [POS_W:0]             cnt_x, ins_p, del_p, sel_p;
  logic                       ins_bad, del_bad, full;
  logic                       is_del;
  logic [CNT_W-1:0]           sp, sp_m1;
  logic                       fs_empty;
  logic                       req_beat;

  assign req_beat  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_free  = !ov_q || rsp_o.ready;

  assign cnt_x   = (POS_W + 1)'(count_q);
  assign ins_p   = (op_q == OP_INS_FRONT) ? (POS_W + 1)'(1) :
                   (op_q == OP_INS_BACK)  ? cnt_x + (POS_W + 1)'(1) :
                                            {1'b0, pos_q};
  assign del_p   = (op_q == OP_DEL_FRONT) ? (POS_W + 1)'(1) :
                   (op_q == OP_DEL_BACK)  ? cnt_x :
                                            {1'b0, pos_q};
  assign ins_bad = (ins_p == '0) || (ins_p > cnt_x + (POS_W + 1)'(1));
  assign del_bad = (del_p == '0) || (del_p > cnt_x);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign is_del  = (op_q == OP_DEL_FRONT) || (op_q == OP_DEL_BACK) || (op_q == OP_DEL_AT);
  assign sel_p   = is_del ? del_p : ins_p;

  // free-slot stack holds fresh - count entries
  assign sp       = fresh_q - count_q;
  assign sp_m1    = sp - CNT_W'(1);
  assign fs_empty = (fresh_q == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_beat) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (op_e'(op_q))
          OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            state_d = (ins_bad || full) ? S_RESP : S_ALLOC;
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (count_q == '0 || del_bad)       state_d = S_RESP;
            else if (count_q == CNT_W'(1))      state_d = S_FREE;
            else if (del_p == (POS_W + 1)'(1))  state_d = S_DEL_HEAD;
            else                                state_d = S_WALK_START;
          end
          OP_DUMP: begin
            state_d = (count_q == '0) ? S_RESP : S_DUMP_RD;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_ALLOC:      state_d = S_ALLOC_GET;
      S_ALLOC_GET: begin
        if (count_q == '0) state_d = S_INS_SOLO;
        else if (first_q)  state_d = S_INS_HEAD;
        else               state_d = S_WALK_START;
      end
      S_INS_SOLO:   state_d = S_RESP;
      S_INS_HEAD:   state_d = S_INS_TAIL;
      S_INS_TAIL:   state_d = S_RESP;
      S_WALK_START: state_d = (steps_q == '0) ? S_LINK_RD : S_WALK;
      S_WALK: begin
        if (steps_q == '0) state_d = S_LINK_RD;
      end
      S_LINK_RD:    state_d = S_LINK_GET;
      S_LINK_GET:   state_d = del_q ? S_DEL_GET : S_INS_PREV;
      S_INS_PREV:   state_d = S_RESP;
      S_DEL_GET:    state_d = S_FREE;
      S_DEL_HEAD:   state_d = S_FREE;
      S_FREE:       state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_DUMP_RD:    state_d = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (out_free && steps_q == '0) state_d = S_IDLE;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    steps_d  = steps_q;
    cur_d    = cur_q;
    slot_d   = slot_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    fresh_d  = fresh_q;
    status_d = status_q;
    del_d    = del_q;
    first_d  = first_q;

    lk_we = 1'b0; lk_waddr = cur_q;  lk_wdata = slot_q;
    lk_re = 1'b0; lk_raddr = cur_q;
    el_we = 1'b0; el_waddr = slot_q;
    el_re = 1'b0; el_raddr = cur_q;
    fs_we = 1'b0; fs_waddr = sp[SLOT_W-1:0]; fs_wdata = slot_q;
    fs_re = 1'b0; fs_raddr = sp_m1[SLOT_W-1:0];

    out_load = 1'b0;
    out_st   = status_q;
    out_el   = '0;
    out_last = 1'b1;

    case (state_q)
      S_DECODE: begin
        del_d    = is_del;
        first_d  = (sel_p == (POS_W + 1)'(1));
        steps_d  = CNT_W'(sel_p - (POS_W + 1)'(2));
        cur_d    = head_q;
        slot_d   = head_q;
        status_d = STS_OK;
        case (op_e'(op_q))
          OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (ins_bad)   status_d = STS_BADPOS;
            else if (full) status_d = STS_FULL;
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (count_q == '0) status_d = STS_EMPTY;
            else if (del_bad)  status_d = STS_BADPOS;
            else if (count_q != CNT_W'(1) && del_p == (POS_W + 1)'(1)) begin
              lk_re    = 1'b1;
              lk_raddr = head_q;
            end
          end
          OP_DUMP: begin
            if (count_q == '0) status_d = STS_EMPTY;
            steps_d = count_q - CNT_W'(1);
          end
          default: status_d = STS_BADPOS;
        endcase
      end
      S_ALLOC: begin
        fs_re = !fs_empty;
      end
      S_ALLOC_GET: begin
        if (fs_empty) begin
          slot_d  = fresh_q[SLOT_W-1:0];
          fresh_d = fresh_q + CNT_W'(1);
        end else begin
          slot_d  = fs_rdata;
        end
        el_we    = 1'b1;
        el_waddr = slot_d;
      end
      S_INS_SOLO: begin
        lk_we    = 1'b1;
        lk_waddr = slot_q;
        lk_wdata = slot_q;
        head_d   = slot_q;
        tail_d   = slot_q;
        count_d  = count_q + CNT_W'(1);
      end
      S_INS_HEAD: begin
        lk_we    = 1'b1;
        lk_waddr = slot_q;
        lk_wdata = head_q;
        head_d   = slot_q;
      end
      S_INS_TAIL: begin
        // close the ring on the new head
        lk_we    = 1'b1;
        lk_waddr = tail_q;
        lk_wdata = head_q;
        count_d  = count_q + CNT_W'(1);
      end
      S_WALK_START: begin
        cur_d = head_q;
        if (steps_q != '0) begin
          lk_re    = 1'b1;
          lk_raddr = head_q;
          steps_d  = steps_q - CNT_W'(1);
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          cur_d = lk_rdata;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
          steps_d  = steps_q - CNT_W'(1);
        end
      end
      S_LINK_RD: begin
        lk_re    = 1'b1;
        lk_raddr = cur_q;
      end
      S_LINK_GET: begin
        if (del_q) begin
          slot_d   = lk_rdata;
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = slot_q;
          lk_wdata = lk_rdata;
        end
      end
      S_INS_PREV: begin
        lk_we    = 1'b1;
        lk_waddr = cur_q;
        lk_wdata = slot_q;
        if (cur_q == tail_q) tail_d = slot_q;
        count_d  = count_q + CNT_W'(1);
      end
      S_DEL_GET: begin
        lk_we    = 1'b1;
        lk_waddr = cur_q;
        lk_wdata = lk_rdata;
        if (slot_q == tail_q) tail_d = cur_q;
      end
      S_DEL_HEAD: begin
        head_d   = lk_rdata;
        lk_we    = 1'b1;
        lk_waddr = tail_q;
        lk_wdata = lk_rdata;
      end
      S_FREE: begin
        fs_we   = 1'b1;
        count_d = count_q - CNT_W'(1);
      end
      S_RESP: begin
        out_load = out_free;
      end
      S_DUMP_RD: begin
        el_re    = 1'b1;
        lk_re    = 1'b1;
        el_raddr = cur_q;
        lk_raddr = cur_q;
      end
      S_DUMP_OUT: begin
        out_st   = STS_OK;
        out_el   = el_rdata;
        out_last = (steps_q == '0);
        if (out_free) begin
          out_load = 1'b1;
          if (steps_q != '0) begin
            steps_d  = steps_q - CNT_W'(1);
            el_re    = 1'b1;
            lk_re    = 1'b1;
            el_raddr = lk_rdata;
            lk_raddr = lk_rdata;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      if (out_load)         ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_beat) begin
      op_q  <= req_i.opcode;
      val_q <= req_i.value;
      pos_q <= req_i.position;
    end
    steps_q  <= steps_d;
    cur_q    <= cur_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    del_q    <= del_d;
    first_q  <= first_d;
    if (out_load) begin
      ost_q   <= out_st;
      oel_q   <= out_el;
      ocnt_q  <= COUNT_W'(count_q);
      olast_q <= out_last;
    end
  end

  assign rsp_o.valid   = ov_q;
  assign rsp_o.status  = ost_q;
  assign rsp_o.element = oel_q;
  assign rsp_o.count   = ocnt_q;
  assign rsp_o.last    = olast_q;

  ple_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  ple_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (val_q),
    .re_i    (el_re),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  ple_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(CAPACITY)) && (fresh_q >= count_q))
    else $error("slot bookkeeping out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.last |-> rsp_o.status == STS_OK)
    else $error("non-final beat with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != STS_OK |-> rsp_o.element == '0)
    else $error("error beat carries an element");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STS_EMPTY |-> rsp_o.count == '0)
    else $error("empty status with elements held");

endmodule
